// ===== design/ctb_pkg.sv =====
// Shared types, constants and helpers for the cascading timer bank.
`timescale 1ns / 1ps

package ctb_pkg;

  // Default build sizes
  localparam int NUM_TIMERS_DEF     = 4;
  localparam int PRESCALE_WIDTH_DEF = 10;

  // Field widths
  localparam int COUNT_W  = 16;
  localparam int CTL_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W   = 4;
  localparam int SND_W    = 2;
  localparam int SEL_W    = 2;
  localparam int PRE_SEL_W = 2;
  localparam int SHIFT_W  = 5;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL0 = 3'd4;

  // Control register bit positions
  localparam int CTL_PRE_LSB = 0;
  localparam int CTL_CASCADE = 2;
  localparam int CTL_IRQ     = 6;
  localparam int CTL_ENABLE  = 7;

  // Prescaler codes
  localparam logic [PRE_SEL_W-1:0] PRE_DIV1    = 2'd0;
  localparam logic [PRE_SEL_W-1:0] PRE_DIV64   = 2'd1;
  localparam logic [PRE_SEL_W-1:0] PRE_DIV256  = 2'd2;
  localparam logic [PRE_SEL_W-1:0] PRE_DIV1024 = 2'd3;

  // Input kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Write strobes and data handed to one timer cell
  typedef struct packed {
    logic                reload_we;
    logic                control_we;
    logic [COUNT_W-1:0]  data;
  } ctb_cfg_t;

  // log2 of the prescale period for a prescaler code
  function automatic logic [SHIFT_W-1:0] period_shift(input logic [PRE_SEL_W-1:0] code);
    logic [SHIFT_W-1:0] sh;
    case (code)
      PRE_DIV1:    sh = 5'd0;
      PRE_DIV64:   sh = 5'd6;
      PRE_DIV256:  sh = 5'd8;
      PRE_DIV1024: sh = 5'd10;
      default:     sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== design/ctb_cell.sv =====
// One timer cell: reload/control registers, prescaler, counter, cascade in/out.
`timescale 1ns / 1ps

module ctb_cell #(
  parameter int   PRESCALE_WIDTH = ctb_pkg::PRESCALE_WIDTH_DEF,
  parameter logic CASCADE_OK     = 1'b1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ctb_pkg::ctb_cfg_t            cfg,
  input  logic                         tick,
  input  logic                         carry_in,
  output logic                         carry_out,
  output logic                         irq_out,
  output logic [ctb_pkg::COUNT_W-1:0]  count
);

  localparam int PW = PRESCALE_WIDTH;

  logic [ctb_pkg::COUNT_W-1:0] reload;
  logic [ctb_pkg::CTL_W-1:0]   control;
  logic [PW-1:0]               prescale;

  logic [ctb_pkg::COUNT_W-1:0] count_next;
  logic [PW-1:0]               prescale_next;
  logic [ctb_pkg::SHIFT_W-1:0] sh;
  logic [PW:0]                 period;
  logic [PW:0]                 pre_inc;
  logic                        enabled;
  logic                        cascaded;
  logic                        bump;
  logic                        over;

  assign enabled  = control[ctb_pkg::CTL_ENABLE];
  assign cascaded = CASCADE_OK && control[ctb_pkg::CTL_CASCADE];

  always_comb begin
    sh = ctb_pkg::period_shift(control[ctb_pkg::CTL_PRE_LSB +: ctb_pkg::PRE_SEL_W]);
    if (32'(sh) > PW) begin
      sh = ctb_pkg::SHIFT_W'(PW);
    end
    period  = (PW+1)'(1) << sh;
    pre_inc = {1'b0, prescale} + (PW+1)'(1);

    prescale_next = prescale;
    bump          = 1'b0;
    if (!enabled) begin
      prescale_next = '0;
    end else if (cascaded) begin
      prescale_next = '0;
      bump          = carry_in;
    end else if (pre_inc >= period) begin
      prescale_next = '0;
      bump          = 1'b1;
    end else begin
      prescale_next = pre_inc[PW-1:0];
    end

    over       = 1'b0;
    count_next = count;
    if (bump) begin
      if (count == '1) begin
        count_next = reload;
        over       = 1'b1;
      end else begin
        count_next = count + ctb_pkg::COUNT_W'(1);
      end
    end
  end

  assign carry_out = tick && over;
  assign irq_out   = carry_out && control[ctb_pkg::CTL_IRQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      reload   <= '0;
      control  <= '0;
      count    <= '0;
      prescale <= '0;
    end else begin
      if (cfg.reload_we) begin
        reload <= cfg.data;
      end
      if (cfg.control_we) begin
        control <= cfg.data[ctb_pkg::CTL_W-1:0];
        // switching on restarts from the reload value
        if (cfg.data[ctb_pkg::CTL_ENABLE] && !enabled) begin
          count    <= reload;
          prescale <= '0;
        end
      end else if (tick) begin
        count    <= count_next;
        prescale <= prescale_next;
      end
    end
  end

endmodule

// ===== design/cascading_timer_bank_core.sv =====
// Top level of the cascading timer bank: cell chain, config decode, output register.
`timescale 1ns / 1ps

// A bank of 16-bit up-counters built as a chain of timer cells. Each request
// is either a clock tick (tuser = 0) or a counter read (tuser = 1, timer in
// s_tdata[1:0]); each request yields exactly one result. Throughput is one
// request per cycle unless m_tready holds the output: the overflow carry ripples
// through the cells within the cycle, and a single output register holds the
// result, with s_tready high whenever that register is empty or being drained.
// On a tick, enabled timers count every 1/64/256/1024 ticks (period clipped
// to 2^PRESCALE_WIDTH) or, when cascaded (not timer 0), on the overflow of
// the timer below. Overflow reloads the counter and flags the overflow, IRQ
// (if enabled) and sound pulse (timers 0 and 1) bits. Config writes (index
// 0..3 reload, 4..7 control) are taken every cycle and should be issued only
// while no request is in flight. Turning a timer on loads its reload value.
module cascading_timer_bank_core #(
  parameter int NUM_TIMERS     = ctb_pkg::NUM_TIMERS_DEF,
  parameter int PRESCALE_WIDTH = ctb_pkg::PRESCALE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [1:0] timer_select, rest zero
  input  logic                            s_tuser,   // [0] kind
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [3:0] overflow_mask, [7:4] irq_mask,
                                                     // [9:8] sound_pulse, [25:10] counter_value
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctb_pkg::COUNT_W-1:0]     cfg_data
);

  // timers reachable from the register map and the result masks
  localparam int NUM_VIS = (NUM_TIMERS < ctb_pkg::MASK_W) ? NUM_TIMERS : ctb_pkg::MASK_W;

  logic s_fire;
  logic cfg_fire;
  logic tick;
  logic is_control;
  logic [ctb_pkg::SEL_W-1:0] cfg_timer;
  logic [ctb_pkg::SEL_W-1:0] sel;

  ctb_pkg::ctb_cfg_t           cell_cfg [NUM_TIMERS];
  logic [NUM_TIMERS:0]         carry;
  logic [NUM_TIMERS-1:0]       irq;
  logic [ctb_pkg::COUNT_W-1:0] counts   [NUM_TIMERS];

  logic [ctb_pkg::MASK_W-1:0]  ovf_mask;
  logic [ctb_pkg::MASK_W-1:0]  irq_mask;
  logic [ctb_pkg::COUNT_W-1:0] read_value;
  logic [31:0]                 result;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign tick      = s_fire && (s_tuser == ctb_pkg::KIND_TICK);
  assign sel       = s_tdata[ctb_pkg::SEL_W-1:0];

  assign is_control = (cfg_index >= ctb_pkg::REG_CONTROL0);
  assign cfg_timer  = is_control ? ctb_pkg::SEL_W'(cfg_index - ctb_pkg::REG_CONTROL0)
                                 : ctb_pkg::SEL_W'(cfg_index - ctb_pkg::REG_RELOAD0);

  assign carry[0] = 1'b0;

  // the cell chain; carry hands overflow to the next timer up
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    if (i < ctb_pkg::MASK_W) begin : g_mapped
      always_comb begin
        cell_cfg[i].data       = cfg_data;
        cell_cfg[i].reload_we  = cfg_fire && !is_control && (cfg_timer == ctb_pkg::SEL_W'(i));
        cell_cfg[i].control_we = cfg_fire && is_control && (cfg_timer == ctb_pkg::SEL_W'(i));
      end
    end else begin : g_unmapped
      // no register slot: stays disabled
      assign cell_cfg[i] = '0;
    end

    ctb_cell #(
      .PRESCALE_WIDTH (PRESCALE_WIDTH),
      .CASCADE_OK     ((i > 0) ? 1'b1 : 1'b0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cell_cfg[i]),
      .tick      (tick),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .irq_out   (irq[i]),
      .count     (counts[i])
    );
  end

  always_comb begin
    ovf_mask   = '0;
    irq_mask   = '0;
    read_value = '0;
    for (int i = 0; i < NUM_VIS; i++) begin
      ovf_mask[i] = carry[i+1];
      irq_mask[i] = irq[i];
      if (sel == ctb_pkg::SEL_W'(i)) begin
        read_value = counts[i];
      end
    end
    result = '0;
    if (s_tuser == ctb_pkg::KIND_READ) begin
      result[25:10] = read_value;
    end else begin
      result[3:0] = ovf_mask;
      result[7:4] = irq_mask;
      result[9:8] = ovf_mask[ctb_pkg::SND_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= result;
    end
  end

endmodule

// ===== tb/cascading_timer_bank_core_test.sv =====
// Self-checking bench for the cascading timer bank: stream requests in, predicted results out.
`timescale 1ns / 1ps

// Requests are ticks or counter reads on the slave stream. Each request gives one result on the
// master stream. An in-bench model of the four timers predicts every result when its request
// is accepted. The monitor then checks each result field by field against the oldest
// prediction. Register writes go in only while the bank is drained. The run covers:
//   - directed items: reset state, an overflow cascading through all timers, the cascade bit ignored on timer 0,
//     a disabled timer blocking the cascade, and switching a timer back on;
//   - random phases: each phase loads a new bank setting, and some phases use extreme settings;
//   - idle patterns: sender/receiver idling at 38%/88%, then 88%/38%, then no idling, plus one
//     long receiver stall that backs the bank up into its input.
module cascading_timer_bank_core_test;

  localparam int NT          = ctb_pkg::NUM_TIMERS_DEF;
  localparam int PW          = ctb_pkg::PRESCALE_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_LEN   = 300;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 42;

  // single control bits
  localparam logic [ctb_pkg::CTL_W-1:0] CTL_EN_BIT  =
    ctb_pkg::CTL_W'(1 << ctb_pkg::CTL_ENABLE);
  localparam logic [ctb_pkg::CTL_W-1:0] CTL_IRQ_BIT =
    ctb_pkg::CTL_W'(1 << ctb_pkg::CTL_IRQ);
  localparam logic [ctb_pkg::CTL_W-1:0] CTL_CAS_BIT =
    ctb_pkg::CTL_W'(1 << ctb_pkg::CTL_CASCADE);

  // one request: kind in tuser, timer select in tdata
  typedef struct packed {
    logic                      kind;
    logic [ctb_pkg::SEL_W-1:0] sel;
  } timer_req_t;

  // one result, same bit order as m_tdata[25:0]
  typedef struct packed {
    logic [ctb_pkg::COUNT_W-1:0] value;
    logic [ctb_pkg::SND_W-1:0]   snd;
    logic [ctb_pkg::MASK_W-1:0]  irq;
    logic [ctb_pkg::MASK_W-1:0]  ovf;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata   = '0;
  logic                          s_tuser   = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [31:0]                   m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ctb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ctb_pkg::COUNT_W-1:0]   cfg_data  = '0;

  cascading_timer_bank_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // ---------------------------------------------------------------------------------------------
  // Timer model: registers, counters and prescalers, updated on register writes and ticks
  // ---------------------------------------------------------------------------------------------
  logic [ctb_pkg::COUNT_W-1:0] mdl_reload   [NT];
  logic [ctb_pkg::CTL_W-1:0]   mdl_ctl      [NT];
  logic [ctb_pkg::COUNT_W-1:0] mdl_count    [NT];
  int unsigned                 mdl_prescale [NT];

  timer_req_t    req_queue[$];    // requests waiting to be driven
  timer_result_t due_results[$];  // predictions waiting for their result
  int            err_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_trigger = 0;          // bumped by the stimulus to ask for one long receiver stall
  logic req_taken = 1'b0;         // request handshake seen at the last rising edge

  // ticks per count for a prescaler code, clipped to the prescaler width
  function automatic int unsigned count_period(logic [ctb_pkg::PRE_SEL_W-1:0] code);
    int unsigned n;
    case (code)
      ctb_pkg::PRE_DIV64:   n = 64;
      ctb_pkg::PRE_DIV256:  n = 256;
      ctb_pkg::PRE_DIV1024: n = 1024;
      default:              n = 1;
    endcase
    if (n > (32'd1 << PW)) n = 32'd1 << PW;
    return n;
  endfunction

  function automatic void apply_reg_write(logic [ctb_pkg::CFG_IDX_W-1:0] idx,
                                          logic [ctb_pkg::COUNT_W-1:0] data);
    logic [ctb_pkg::SEL_W-1:0] t;
    logic [ctb_pkg::CTL_W-1:0] nv;
    if (idx < ctb_pkg::REG_CONTROL0) begin
      t = ctb_pkg::SEL_W'(idx - ctb_pkg::REG_RELOAD0);
      mdl_reload[t] = data;
    end else begin
      t  = ctb_pkg::SEL_W'(idx - ctb_pkg::REG_CONTROL0);
      nv = data[ctb_pkg::CTL_W-1:0];
      // switching on loads the counter and restarts the prescaler
      if (nv[ctb_pkg::CTL_ENABLE] && !mdl_ctl[t][ctb_pkg::CTL_ENABLE]) begin
        mdl_count[t]    = mdl_reload[t];
        mdl_prescale[t] = 0;
      end
      mdl_ctl[t] = nv;
    end
  endfunction

  // advance the model by one request and return the result it should produce
  function automatic timer_result_t advance_timers(logic kind, logic [ctb_pkg::SEL_W-1:0] sel);
    timer_result_t r;
    logic        carry;
    logic        bump;
    logic        over;
    int unsigned p;
    r     = '0;
    carry = 1'b0;
    if (kind == ctb_pkg::KIND_READ) begin
      r.value = mdl_count[sel];
    end else begin
      for (int t = 0; t < NT; t++) begin
        bump = 1'b0;
        over = 1'b0;
        if (!mdl_ctl[t][ctb_pkg::CTL_ENABLE]) begin
          mdl_prescale[t] = 0;
        end else if (t > 0 && mdl_ctl[t][ctb_pkg::CTL_CASCADE]) begin
          // cascaded: counts on the overflow of the timer below
          mdl_prescale[t] = 0;
          bump = carry;
        end else begin
          // timer 0 ignores its cascade bit and always uses the prescaler
          p = mdl_prescale[t] + 1;
          if (p >= count_period(mdl_ctl[t][ctb_pkg::CTL_PRE_LSB +: ctb_pkg::PRE_SEL_W])) begin
            p    = 0;
            bump = 1'b1;
          end
          mdl_prescale[t] = p;
        end
        if (bump) begin
          if (mdl_count[t] == '1) begin
            mdl_count[t] = mdl_reload[t];
            over = 1'b1;
          end else begin
            mdl_count[t] = mdl_count[t] + 1'b1;
          end
        end
        if (over) begin
          r.ovf[t] = 1'b1;
          if (mdl_ctl[t][ctb_pkg::CTL_IRQ]) r.irq[t] = 1'b1;
          if (t < ctb_pkg::SND_W) r.snd[t] = 1'b1;
        end
        carry = over;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("ERROR at %0t ns: %s: want 0x%0h, got 0x%0h", $time, what, want, got);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------------------------
  // Request driver: presents queued requests, idling at random between them
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    timer_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.kind;
        s_tdata  <= {{(8 - ctb_pkg::SEL_W){1'b0}}, nxt.sel};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus a long hold-off when asked
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    int stall_left;
    int stall_seen;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
      stall_seen = 0;
    end else begin
      if (stall_seen != stall_trigger) begin
        stall_seen = stall_trigger;
        stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Monitor: predict on request handshake, check on result handshake
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin : watch_streams
    timer_result_t want;
    timer_result_t got;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        due_results.push_back(advance_timers(s_tuser, s_tdata[ctb_pkg::SEL_W-1:0]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(timer_result_t)-1:0];
        if (due_results.size() == 0) begin
          report_mismatch("result with no request pending", 0, 32'(got));
        end else begin
          want = due_results.pop_front();
          if (got.ovf !== want.ovf)
            report_mismatch("overflow_mask", 32'(want.ovf), 32'(got.ovf));
          if (got.irq !== want.irq)
            report_mismatch("irq_mask", 32'(want.irq), 32'(got.irq));
          if (got.snd !== want.snd)
            report_mismatch("sound_pulse", 32'(want.snd), 32'(got.snd));
          if (got.value !== want.value)
            report_mismatch("counter_value", 32'(want.value), 32'(got.value));
        end
      end
    end
  end

  // hard stop on a hang
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cascading_timer_bank_core_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------------
  logic [ctb_pkg::COUNT_W-1:0] plan_reload [NT];
  logic [ctb_pkg::CTL_W-1:0]   plan_ctl    [NT];

  task automatic queue_req(logic kind, int sel);
    timer_req_t r;
    r.kind = kind;
    r.sel  = ctb_pkg::SEL_W'(sel);
    req_queue.push_back(r);
  endtask

  task automatic write_reg(logic [ctb_pkg::CFG_IDX_W-1:0] idx,
                           logic [ctb_pkg::COUNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reloads first, so a timer switched on picks up its new reload value
  task automatic program_bank();
    for (int t = 0; t < NT; t++)
      write_reg(ctb_pkg::REG_RELOAD0 + ctb_pkg::CFG_IDX_W'(t), plan_reload[t]);
    for (int t = 0; t < NT; t++)
      write_reg(ctb_pkg::REG_CONTROL0 + ctb_pkg::CFG_IDX_W'(t),
                {{(ctb_pkg::COUNT_W - ctb_pkg::CTL_W){1'b0}}, plan_ctl[t]});
  endtask

  // wait until every queued request has produced its result
  task automatic wait_drain();
    while (req_queue.size() != 0 || s_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [ctb_pkg::CTL_W-1:0] c;
    for (int t = 0; t < NT; t++) begin
      mdl_reload[t]   = '0;
      mdl_ctl[t]      = '0;
      mdl_count[t]    = '0;
      mdl_prescale[t] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    recv_idle_pct = 88;

    // out of reset everything is off: ticks give no flags, reads give zero
    queue_req(ctb_pkg::KIND_TICK, 0);
    for (int s = 0; s < NT; s++) queue_req(ctb_pkg::KIND_READ, s);
    wait_drain();

    // timer 0 two counts from overflow, cascade bit set but ignored; 1..3 cascaded,
    // 1 and 2 sitting at all-ones so the first overflow ripples to the top
    plan_reload = '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000};
    plan_ctl[0] = CTL_EN_BIT | CTL_IRQ_BIT | CTL_CAS_BIT | ctb_pkg::CTL_W'(ctb_pkg::PRE_DIV1);
    plan_ctl[1] = CTL_EN_BIT | CTL_IRQ_BIT | CTL_CAS_BIT;
    plan_ctl[2] = CTL_EN_BIT | CTL_CAS_BIT;
    plan_ctl[3] = CTL_EN_BIT | CTL_IRQ_BIT | CTL_CAS_BIT;
    program_bank();
    queue_req(ctb_pkg::KIND_TICK, 0);
    queue_req(ctb_pkg::KIND_TICK, 0);
    for (int s = 0; s < NT; s++) queue_req(ctb_pkg::KIND_READ, s);
    repeat (3) queue_req(ctb_pkg::KIND_TICK, 0);
    wait_drain();

    // timer 1 off: it holds and stops the cascade from reaching 2 and 3
    write_reg(ctb_pkg::REG_CONTROL0 + ctb_pkg::CFG_IDX_W'(1),
              {{(ctb_pkg::COUNT_W - ctb_pkg::CTL_W){1'b0}}, plan_ctl[1] & ~CTL_EN_BIT});
    queue_req(ctb_pkg::KIND_TICK, 0);
    queue_req(ctb_pkg::KIND_TICK, 0);
    queue_req(ctb_pkg::KIND_READ, 1);
    queue_req(ctb_pkg::KIND_READ, 2);
    wait_drain();

    // back on: counter reloads
    write_reg(ctb_pkg::REG_CONTROL0 + ctb_pkg::CFG_IDX_W'(1),
              {{(ctb_pkg::COUNT_W - ctb_pkg::CTL_W){1'b0}}, plan_ctl[1]});
    queue_req(ctb_pkg::KIND_TICK, 0);
    queue_req(ctb_pkg::KIND_TICK, 0);
    queue_req(ctb_pkg::KIND_READ, 1);
    wait_drain();

    // random phases, three per idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0:       begin send_idle_pct = 38; recv_idle_pct = 88; end
        1:       begin send_idle_pct = 88; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase

      for (int t = 0; t < NT; t++) begin
        // reloads mostly near the top so overflows come often
        if ($urandom_range(3) == 0)
          plan_reload[t] = ctb_pkg::COUNT_W'($urandom);
        else
          plan_reload[t] = 16'hFFFF - ctb_pkg::COUNT_W'($urandom_range(63));
        c = ctb_pkg::CTL_W'($urandom_range(255));
        c[ctb_pkg::CTL_ENABLE] = ($urandom_range(7) != 0);
        if ($urandom_range(3) != 0)
          c[ctb_pkg::CTL_PRE_LSB +: ctb_pkg::PRE_SEL_W] = ctb_pkg::PRE_DIV1;
        plan_ctl[t] = c;
        // extreme settings
        if (ph == 2) begin
          plan_reload[t] = '1;
          plan_ctl[t]    = '1;
        end else if (ph == 4) begin
          plan_reload[t] = '0;
        end else if (ph == 5) begin
          plan_ctl[t] = '0;
        end
      end
      program_bank();

      // first no-idle phase: long receiver hold-off while requests keep coming
      if (ph == 6) stall_trigger++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(3) == 0)
          queue_req(ctb_pkg::KIND_READ, $urandom_range(NT - 1));
        else
          queue_req(ctb_pkg::KIND_TICK, $urandom_range(NT - 1));
      end
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("cascading_timer_bank_core_test: PASS");
    else
      $display("cascading_timer_bank_core_test: FAIL");
    $finish;
  end

endmodule
